[hdl/cke_pkg.sv]
// Shared types, key codes and constants for the calculator keystroke engine.
package cke_pkg;

    localparam int RESULT_W = 28;
    localparam int KEY_W = 8;
    localparam int unsigned VALUE_LIMIT_DEF = 99999999;

    localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;
    localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;
    localparam logic [KEY_W-1:0] KEY_PLUS  = 8'h2B;
    localparam logic [KEY_W-1:0] KEY_MINUS = 8'h2D;
    localparam logic [KEY_W-1:0] KEY_TIMES = 8'h2A;
    localparam logic [KEY_W-1:0] KEY_SLASH = 8'h2F;
    localparam logic [KEY_W-1:0] KEY_EQUAL = 8'h3D;

    localparam logic OPC_KEY = 1'b0;
    localparam logic OPC_EOL = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_CALC,
        CS_EMIT
    } cs_state_t;

    typedef enum logic [1:0] {
        AS_IDLE,
        AS_ITER,
        AS_SIGN
    } as_state_t;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key_code;
    } in_item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result_value;
        logic                       error_flag;
    } out_item_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_cmd_t;

    typedef struct packed {
        logic done;
        logic err;
    } alu_sts_t;

    function automatic op_t decode_op(input logic [KEY_W-1:0] key);
        op_t op;
        case (key)
            KEY_PLUS:  op = OP_ADD;
            KEY_MINUS: op = OP_SUB;
            KEY_TIMES: op = OP_MUL;
            KEY_SLASH: op = OP_DIV;
            default:   op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

[hdl/calculator_keystroke_engine_top.sv]
// A digit, an ignored key or an operator without arithmetic is taken without leaving idle.
// Add, subtract and division by zero pass the sequencer's calculation state while the unit
// runs only its iterate state; multiply and divide loop bit-serially there, then take the sign step.
// End of line enters the emit state; the result register then loads and all state clears,
// but it waits for as long as an earlier result is still held unaccepted.
// Reset (aresetn low, synchronous) clears the accumulator, entry, operator, error and m_valid.
module calculator_keystroke_engine_top #(
    parameter int unsigned VALUE_LIMIT = cke_pkg::VALUE_LIMIT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cke_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output cke_pkg::out_item_t m_item
);
    import cke_pkg::*;

    localparam int VAL_W = $clog2(VALUE_LIMIT + 1) + 1;

    alu_cmd_t                alu_cmd;
    alu_sts_t                alu_sts;
    logic signed [VAL_W-1:0] alu_a, alu_b, alu_res;
    logic                    emit;
    logic                    out_free;
    out_item_t               out_item;

    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_item_reg, m_item_next;

    cke_ctrl #(
        .VALUE_LIMIT(VALUE_LIMIT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .out_free (out_free),
        .emit     (emit),
        .out_item (out_item),
        .alu_cmd  (alu_cmd),
        .alu_a    (alu_a),
        .alu_b    (alu_b),
        .alu_sts  (alu_sts),
        .alu_res  (alu_res)
    );

    cke_alu #(
        .VALUE_LIMIT(VALUE_LIMIT)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (alu_cmd),
        .a       (alu_a),
        .b       (alu_b),
        .sts     (alu_sts),
        .res     (alu_res)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_item_next  = out_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[hdl/cke_alu.sv]
// Iterative arithmetic unit: one shared adder serves add, subtract, multiply and divide.
module cke_alu #(
    parameter int unsigned VALUE_LIMIT = cke_pkg::VALUE_LIMIT_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  cke_pkg::alu_cmd_t                            cmd,
    input  logic signed [$clog2(VALUE_LIMIT+1):0]        a,
    input  logic signed [$clog2(VALUE_LIMIT+1):0]        b,
    output cke_pkg::alu_sts_t                            sts,
    output logic signed [$clog2(VALUE_LIMIT+1):0]        res
);
    import cke_pkg::*;

    localparam int MAG_W = $clog2(VALUE_LIMIT + 1);
    localparam int VAL_W = MAG_W + 1;
    localparam int SUM_W = MAG_W + 3;
    localparam int CNT_W = $clog2(MAG_W);
    localparam logic signed [SUM_W-1:0] LIM_P = SUM_W'(VALUE_LIMIT);
    localparam logic signed [SUM_W-1:0] LIM_N = -SUM_W'(VALUE_LIMIT);

    as_state_t               state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [VAL_W-1:0] a_reg, a_next;
    logic signed [VAL_W-1:0] b_reg, b_next;
    logic [MAG_W-1:0]        amag_reg, amag_next;
    logic [MAG_W-1:0]        bmag_reg, bmag_next;
    logic [MAG_W-1:0]        part_reg, part_next;
    logic                    neg_reg, neg_next;
    logic                    ovf_reg, ovf_next;
    logic signed [VAL_W-1:0] res_reg, res_next;
    logic                    done_reg, done_next;
    logic                    err_reg, err_next;

    logic signed [SUM_W-1:0] x, y, s;
    logic                    sub;
    logic                    last_step;
    logic                    div_zero;
    logic signed [VAL_W-1:0] a_abs, b_abs;

    assign s = x + (y ^ {SUM_W{sub}}) + SUM_W'(sub);
    assign last_step = (cnt_reg == '0);
    assign div_zero = (bmag_reg == '0);
    assign a_abs = a[VAL_W-1] ? -a : a;
    assign b_abs = b[VAL_W-1] ? -b : b;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            AS_IDLE: begin
                if (cmd.start) begin
                    state_next = AS_ITER;
                end
            end
            AS_ITER: begin
                if (op_reg == OP_ADD || op_reg == OP_SUB || op_reg == OP_NONE) begin
                    state_next = AS_IDLE;
                end else if (op_reg == OP_DIV && div_zero) begin
                    state_next = AS_IDLE;
                end else if (last_step) begin
                    state_next = AS_SIGN;
                end
            end
            AS_SIGN: begin
                state_next = AS_IDLE;
            end
            default: begin
                state_next = AS_IDLE;
            end
        endcase
    end

    always_comb begin
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        amag_next = amag_reg;
        bmag_next = bmag_reg;
        part_next = part_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        err_next  = err_reg;
        x         = '0;
        y         = '0;
        sub       = 1'b0;
        case (state_reg)
            AS_IDLE: begin
                if (cmd.start) begin
                    op_next   = cmd.op;
                    cnt_next  = CNT_W'(MAG_W - 1);
                    a_next    = a;
                    b_next    = b;
                    amag_next = a_abs[MAG_W-1:0];
                    bmag_next = b_abs[MAG_W-1:0];
                    part_next = '0;
                    neg_next  = a[VAL_W-1] ^ b[VAL_W-1];
                    ovf_next  = 1'b0;
                end
            end
            AS_ITER: begin
                cnt_next = cnt_reg - 1'b1;
                case (op_reg)
                    OP_MUL: begin
                        x = SUM_W'({part_reg, 1'b0});
                        y = amag_reg[MAG_W-1] ? SUM_W'(bmag_reg) : '0;
                        part_next = s[MAG_W-1:0];
                        amag_next = {amag_reg[MAG_W-2:0], 1'b0};
                        if (s > LIM_P) begin
                            ovf_next = 1'b1;
                        end
                    end
                    OP_DIV: begin
                        x   = SUM_W'({part_reg, amag_reg[MAG_W-1]});
                        y   = SUM_W'(bmag_reg);
                        sub = 1'b1;
                        if (div_zero) begin
                            done_next = 1'b1;
                            err_next  = 1'b1;
                            res_next  = a_reg;
                        end else if (!s[SUM_W-1]) begin
                            part_next = s[MAG_W-1:0];
                            amag_next = {amag_reg[MAG_W-2:0], 1'b1};
                        end else begin
                            part_next = x[MAG_W-1:0];
                            amag_next = {amag_reg[MAG_W-2:0], 1'b0};
                        end
                    end
                    default: begin
                        x         = SUM_W'(a_reg);
                        y         = SUM_W'(b_reg);
                        sub       = (op_reg == OP_SUB);
                        done_next = 1'b1;
                        err_next  = (s > LIM_P) || (s < LIM_N);
                        res_next  = s[VAL_W-1:0];
                    end
                endcase
            end
            AS_SIGN: begin
                y         = (op_reg == OP_MUL) ? SUM_W'(part_reg) : SUM_W'(amag_reg);
                sub       = neg_reg;
                done_next = 1'b1;
                err_next  = ovf_reg;
                res_next  = s[VAL_W-1:0];
            end
            default: begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        amag_reg <= amag_next;
        bmag_reg <= bmag_next;
        part_reg <= part_next;
        neg_reg  <= neg_next;
        ovf_reg  <= ovf_next;
        res_reg  <= res_next;
        err_reg  <= err_next;
    end

    assign sts.done = done_reg;
    assign sts.err  = err_reg;
    assign res      = res_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> state_reg == AS_IDLE)
        else $error("Operation started while the unit was busy.");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("Completion held for more than one cycle.");

    a_done_no_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> !done_reg)
        else $error("Completion reported in the cycle after a start.");

endmodule

[hdl/cke_ctrl.sv]
// Keystroke sequencer: holds calculator state, decodes keys and drives the arithmetic unit.
module cke_ctrl #(
    parameter int unsigned VALUE_LIMIT = cke_pkg::VALUE_LIMIT_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  cke_pkg::in_item_t                     s_item,
    input  logic                                  out_free,
    output logic                                  emit,
    output cke_pkg::out_item_t                    out_item,
    output cke_pkg::alu_cmd_t                     alu_cmd,
    output logic signed [$clog2(VALUE_LIMIT+1):0] alu_a,
    output logic signed [$clog2(VALUE_LIMIT+1):0] alu_b,
    input  cke_pkg::alu_sts_t                     alu_sts,
    input  logic signed [$clog2(VALUE_LIMIT+1):0] alu_res
);
    import cke_pkg::*;

    localparam int MAG_W = $clog2(VALUE_LIMIT + 1);
    localparam int VAL_W = MAG_W + 1;
    localparam int NXT_W = MAG_W + 4;
    localparam logic signed [VAL_W-1:0] LIM_P = VAL_W'(VALUE_LIMIT);
    localparam logic signed [VAL_W-1:0] LIM_N = -VAL_W'(VALUE_LIMIT);

    cs_state_t               state_reg, state_next;
    logic signed [VAL_W-1:0] acc_reg, acc_next;
    logic [MAG_W-1:0]        entry_reg, entry_next;
    logic                    entry_vld_reg, entry_vld_next;
    op_t                     pend_reg, pend_next;
    logic signed [VAL_W-1:0] rep_reg, rep_next;
    logic                    eq_run_reg, eq_run_next;
    logic                    dig_run_reg, dig_run_next;
    logic                    err_reg, err_next;

    logic                    accept;
    logic                    calc_start;
    op_t                     calc_op;
    logic signed [VAL_W-1:0] calc_b;
    logic signed [VAL_W-1:0] entry_s;
    logic signed [VAL_W-1:0] shown;

    assign accept  = s_valid && s_ready;
    assign entry_s = {1'b0, entry_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: begin
                if (s_valid) begin
                    if (s_item.opcode == OPC_EOL) begin
                        state_next = CS_EMIT;
                    end else if (calc_start) begin
                        state_next = CS_CALC;
                    end
                end
            end
            CS_CALC: begin
                if (alu_sts.done) begin
                    state_next = CS_IDLE;
                end
            end
            CS_EMIT: begin
                if (out_free) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = (state_reg == CS_IDLE);
        emit    = (state_reg == CS_EMIT) && out_free;
    end

    always_comb begin
        op_t                 key_op;
        op_t                 eff_pend;
        logic [MAG_W-1:0]    base;
        logic [NXT_W-1:0]    nxt;
        logic signed [VAL_W-1:0] operand;

        acc_next       = acc_reg;
        entry_next     = entry_reg;
        entry_vld_next = entry_vld_reg;
        pend_next      = pend_reg;
        rep_next       = rep_reg;
        eq_run_next    = eq_run_reg;
        dig_run_next   = dig_run_reg;
        err_next       = err_reg;
        calc_start     = 1'b0;
        calc_op        = pend_reg;
        calc_b         = entry_s;

        key_op   = decode_op(s_item.key_code);
        eff_pend = eq_run_reg ? OP_NONE : pend_reg;
        base     = dig_run_reg ? entry_reg : '0;
        nxt      = NXT_W'({base, 3'b000}) + NXT_W'({base, 1'b0})
                 + NXT_W'(s_item.key_code[3:0]);
        operand  = entry_vld_reg ? entry_s : acc_reg;

        if (accept && s_item.opcode == OPC_KEY && !err_reg) begin
            if (s_item.key_code inside {[KEY_ZERO:KEY_NINE]}) begin
                if (eq_run_reg) begin
                    pend_next   = OP_NONE;
                    eq_run_next = 1'b0;
                end
                entry_vld_next = 1'b1;
                dig_run_next   = 1'b1;
                if (nxt <= NXT_W'(VALUE_LIMIT)) begin
                    entry_next = nxt[MAG_W-1:0];
                end else begin
                    entry_next = base;
                end
            end else if (key_op != OP_NONE) begin
                eq_run_next  = 1'b0;
                dig_run_next = 1'b0;
                if (entry_vld_reg) begin
                    if (eff_pend != OP_NONE) begin
                        calc_start = 1'b1;
                        calc_op    = eff_pend;
                        calc_b     = entry_s;
                    end else begin
                        acc_next = entry_s;
                    end
                    entry_vld_next = 1'b0;
                end
                pend_next = key_op;
            end else if (s_item.key_code == KEY_EQUAL) begin
                dig_run_next = 1'b0;
                if (eq_run_reg) begin
                    if (pend_reg != OP_NONE) begin
                        calc_start = 1'b1;
                        calc_b     = rep_reg;
                    end
                end else begin
                    eq_run_next = 1'b1;
                    if (pend_reg != OP_NONE) begin
                        rep_next       = operand;
                        entry_vld_next = 1'b0;
                        calc_start     = 1'b1;
                        calc_b         = operand;
                    end
                end
            end
        end

        if (state_reg == CS_CALC && alu_sts.done) begin
            if (alu_sts.err) begin
                err_next = 1'b1;
            end else begin
                acc_next = alu_res;
            end
        end

        if (emit) begin
            acc_next       = '0;
            entry_next     = '0;
            entry_vld_next = 1'b0;
            pend_next      = OP_NONE;
            rep_next       = '0;
            eq_run_next    = 1'b0;
            dig_run_next   = 1'b0;
            err_next       = 1'b0;
        end
    end

    assign alu_cmd.start = calc_start;
    assign alu_cmd.op    = calc_op;
    assign alu_a         = acc_reg;
    assign alu_b         = calc_b;

    assign shown = err_reg ? '0 : (entry_vld_reg ? entry_s : acc_reg);
    assign out_item.result_value = RESULT_W'(shown);
    assign out_item.error_flag   = err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CS_IDLE;
            acc_reg       <= '0;
            entry_reg     <= '0;
            entry_vld_reg <= 1'b0;
            pend_reg      <= OP_NONE;
            rep_reg       <= '0;
            eq_run_reg    <= 1'b0;
            dig_run_reg   <= 1'b0;
            err_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            entry_reg     <= entry_next;
            entry_vld_reg <= entry_vld_next;
            pend_reg      <= pend_next;
            rep_reg       <= rep_next;
            eq_run_reg    <= eq_run_next;
            dig_run_reg   <= dig_run_next;
            err_reg       <= err_next;
        end
    end

    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_sts.done |-> state_reg == CS_CALC)
        else $error("Arithmetic result arrived outside a calculation.");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg && !emit |=> err_reg)
        else $error("Error flag cleared without an end of line.");

    a_clear_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> acc_reg == '0 && !entry_vld_reg && !err_reg && pend_reg == OP_NONE)
        else $error("State not cleared after a result was issued.");

    a_acc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= LIM_P && acc_reg >= LIM_N && entry_reg <= MAG_W'(VALUE_LIMIT))
        else $error("Accumulator or entry beyond the value limit.");

endmodule

[sim/keystroke_display_checker.sv]
// Checker that predicts the displayed result of each end-of-line item and compares it.
module keystroke_display_checker #(
    parameter int unsigned LIMIT = cke_pkg::VALUE_LIMIT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  cke_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  cke_pkg::out_item_t m_item,
    output int                 mismatches,
    output int                 awaiting,
    output int                 results_seen,
    output int                 error_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import cke_pkg::*;

    longint    acc_q;
    longint    entry_q;
    longint    operand_q;
    bit        entry_pending;
    bit        eq_run;
    bit        digit_run;
    bit        err_q;
    op_t       pend_op;
    out_item_t pending_displays[$];

    initial begin
        mismatches = 0;
        awaiting = 0;
        results_seen = 0;
        error_results = 0;
    end

    function automatic void clear_calc();
        acc_q = 0;
        entry_q = 0;
        operand_q = 0;
        entry_pending = 0;
        eq_run = 0;
        digit_run = 0;
        err_q = 0;
        pend_op = OP_NONE;
    endfunction

    function automatic longint fold_operation(op_t op, longint a, longint b);
        longint r;
        r = a;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV: begin
                if (b == 0) begin
                    err_q = 1;
                    return a;
                end
                r = a / b;
            end
            default: r = a;
        endcase
        if (r > longint'(LIMIT) || r < -longint'(LIMIT)) begin
            err_q = 1;
            return a;
        end
        return r;
    endfunction

    function automatic void close_equals_run();
        if (eq_run) begin
            pend_op = OP_NONE;
            eq_run = 0;
        end
    endfunction

    function automatic void press_key(in_item_t it);
        out_item_t shown;
        longint    v;
        op_t       op;
        case (it.key_code)
            KEY_PLUS:  op = OP_ADD;
            KEY_MINUS: op = OP_SUB;
            KEY_TIMES: op = OP_MUL;
            KEY_SLASH: op = OP_DIV;
            default:   op = OP_NONE;
        endcase
        if (it.opcode == OPC_EOL) begin
            v = entry_pending ? entry_q : acc_q;
            if (err_q) begin
                v = 0;
            end
            shown.result_value = v[RESULT_W-1:0];
            shown.error_flag = err_q;
            pending_displays.push_back(shown);
            clear_calc();
        end else if (err_q) begin
            return;
        end else if (it.key_code >= KEY_ZERO && it.key_code <= KEY_NINE) begin
            close_equals_run();
            if (!digit_run) begin
                entry_q = 0;
                entry_pending = 1;
                digit_run = 1;
            end
            v = entry_q * 10 + longint'(it.key_code - KEY_ZERO);
            if (v <= longint'(LIMIT)) begin
                entry_q = v;
            end
        end else if (op != OP_NONE) begin
            close_equals_run();
            digit_run = 0;
            if (entry_pending) begin
                if (pend_op != OP_NONE) begin
                    acc_q = fold_operation(pend_op, acc_q, entry_q);
                end else begin
                    acc_q = entry_q;
                end
                entry_pending = 0;
            end
            pend_op = op;
        end else if (it.key_code == KEY_EQUAL) begin
            digit_run = 0;
            if (eq_run) begin
                if (pend_op != OP_NONE) begin
                    acc_q = fold_operation(pend_op, acc_q, operand_q);
                end
            end else begin
                eq_run = 1;
                if (pend_op != OP_NONE) begin
                    operand_q = entry_pending ? entry_q : acc_q;
                    entry_pending = 0;
                    acc_q = fold_operation(pend_op, acc_q, operand_q);
                end
            end
        end
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            clear_calc();
            pending_displays.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_item.error_flag) begin
                    error_results++;
                end
                if (pending_displays.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result, value %0d error %0b", $realtime,
                                 m_item.result_value, m_item.error_flag);
                    end
                end else begin
                    want = pending_displays.pop_front();
                    if (m_item.result_value !== want.result_value ||
                        m_item.error_flag !== want.error_flag) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected value %0d error %0b, got value %0d error %0b",
                                     $realtime, want.result_value, want.error_flag,
                                     m_item.result_value, m_item.error_flag);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                press_key(s_item);
            end
        end
        awaiting = pending_displays.size();
    end

endmodule

[sim/calculator_keystroke_engine_top_tb.sv]
// Testbench top: clock, reset, keystroke stimulus, result back-pressure and the verdict.
module calculator_keystroke_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cke_pkg::*;

    localparam logic [KEY_W-1:0] KEY_LETTER_X = 8'h78;
    localparam int TARGET_ITEMS = 850;
    localparam int FLOOD_CYCLES = 400;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    int mismatches;
    int awaiting;
    int results_seen;
    int error_results;
    int items_sent;
    int directed_items;
    bit sender_calm;
    bit flood_go;

    calculator_keystroke_engine_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    keystroke_display_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .mismatches    (mismatches),
        .awaiting      (awaiting),
        .results_seen  (results_seen),
        .error_results (error_results)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("calculator_keystroke_engine_top verification failed");
        $finish;
    end

    function automatic int pause_len(bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] pick_operator();
        case ($urandom_range(0, 3))
            0: return KEY_PLUS;
            1: return KEY_MINUS;
            2: return KEY_TIMES;
            default: return KEY_SLASH;
        endcase
    endfunction

    task automatic push_key(input logic opc, input logic [KEY_W-1:0] key);
        int gap;
        gap = pause_len(sender_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= '{opcode: opc, key_code: key};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic type_value(input longint value);
        int     digits[$];
        longint v;
        v = value;
        if (v == 0) begin
            digits.push_front(0);
        end
        while (v > 0) begin
            digits.push_front(int'(v % 10));
            v = v / 10;
        end
        foreach (digits[i]) begin
            push_key(OPC_KEY, KEY_W'(KEY_ZERO + digits[i]));
        end
    endtask

    task automatic type_number();
        int len;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            len = $urandom_range(1, 2);
        end else if (r < 90) begin
            len = $urandom_range(3, 5);
        end else begin
            len = $urandom_range(6, 10);
        end
        repeat (len) push_key(OPC_KEY, KEY_W'(KEY_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic type_expression();
        int terms;
        int equals;
        sender_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                push_key(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            return;
        end
        terms = $urandom_range(1, 4);
        if ($urandom_range(0, 9) == 0) begin
            push_key(OPC_KEY, pick_operator());
        end
        for (int t = 0; t < terms; t++) begin
            type_number();
            if ($urandom_range(0, 9) == 0) begin
                push_key(OPC_KEY, 8'($urandom_range(0, 255)));
            end
            if (t < terms - 1) begin
                push_key(OPC_KEY, pick_operator());
                if ($urandom_range(0, 19) == 0) begin
                    push_key(OPC_KEY, pick_operator());
                end
            end
        end
        equals = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : 1;
        repeat (equals) push_key(OPC_KEY, KEY_EQUAL);
        case ($urandom_range(0, 9))
            0: type_number();
            1: begin
                push_key(OPC_KEY, pick_operator());
                type_number();
                push_key(OPC_KEY, KEY_EQUAL);
            end
            default: ;
        endcase
        push_key(OPC_EOL, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int  gap;
        bit  rx_calm;
        m_ready = 1'b0;
        rx_calm = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            if (flood_go) begin
                flood_go = 1'b0;
                m_ready <= 1'b0;
                repeat (FLOOD_CYCLES) @(negedge aclk);
            end
            if ($urandom_range(0, 19) == 0) begin
                rx_calm = ~rx_calm;
            end
            gap = pause_len(rx_calm);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    end

    initial begin
        int waited;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        items_sent = 0;
        sender_calm = 1'b0;
        flood_go = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Entry limit, squaring overflow, keys ignored after an error.
        type_value(999999999);
        push_key(OPC_KEY, KEY_TIMES);
        push_key(OPC_KEY, KEY_EQUAL);
        push_key(OPC_KEY, KEY_LETTER_X);
        push_key(OPC_EOL, '1);
        // Division by zero.
        type_value(7);
        push_key(OPC_KEY, KEY_SLASH);
        type_value(0);
        push_key(OPC_KEY, KEY_EQUAL);
        push_key(OPC_EOL, '0);
        // Operator with no entry, then a repeated equals.
        push_key(OPC_KEY, KEY_MINUS);
        type_value(5);
        push_key(OPC_KEY, KEY_EQUAL);
        push_key(OPC_KEY, KEY_EQUAL);
        push_key(OPC_EOL, '1);
        // Equals with no entry uses the accumulator as operand.
        type_value(3);
        push_key(OPC_KEY, KEY_PLUS);
        push_key(OPC_KEY, KEY_EQUAL);
        push_key(OPC_EOL, '0);
        directed_items = items_sent;

        flood_go = 1'b1;
        while (items_sent < directed_items + TARGET_ITEMS) begin
            type_expression();
        end
        s_valid <= 1'b0;

        waited = 0;
        while (awaiting != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (40) @(posedge aclk);
        if (awaiting != 0) begin
            $display("%0d expected results never arrived", awaiting);
        end

        $display("Sent %0d keystroke items, %0d of them directed.", items_sent, directed_items);
        $display("Checked %0d displayed results, %0d with the error flag set.",
                 results_seen, error_results);
        if (mismatches == 0 && awaiting == 0) begin
            $display("calculator_keystroke_engine_top verification clean");
        end else begin
            $display("calculator_keystroke_engine_top verification failed");
        end
        $finish;
    end

endmodule
